// File: hdl/gbr_pkg.sv
// Shared constants and types for the 3x3 Gaussian blur block.
// Depends on nothing; gbr_line_buf, gbr_lane and the top level import it.
package gbr_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  // width of the row-length compare, wide enough for the register and the limit
  localparam int WX        = (COL_W + 1 > 11) ? COL_W + 1 : 11;
  localparam int LB_W      = 48;  // {upper row, lower row} per column
  localparam int NUM_LANES = 3;

  // register indexes, byte address 4*i
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_WC     = 3'd2;
  localparam logic [2:0] REG_WE     = 3'd3;
  localparam logic [2:0] REG_WK     = 3'd4;

  typedef struct packed {
    logic en1;  // load first stage (tap sums)
    logic en2;  // load product stage
    logic en3;  // load output register
  } gbr_ctrl_t;

  typedef struct packed {
    logic [12:0] center;
    logic [12:0] edge_w;
    logic [12:0] corner;
  } gbr_weights_t;

endpackage

// File: hdl/gbr_if.sv
// Valid/ready stream interfaces for the pixel input and the filtered output.
// No dependencies.
interface gbr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan_a_in;
  logic [7:0] chan_b_in;
  logic [7:0] chan_c_in;
  modport source (output valid, chan_a_in, chan_b_in, chan_c_in, input ready);
  modport sink   (input valid, chan_a_in, chan_b_in, chan_c_in, output ready);
endinterface

interface gbr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan_a_out;
  logic [7:0] chan_b_out;
  logic [7:0] chan_c_out;
  logic [9:0] out_row;
  logic [9:0] out_col;
  logic       frame_end;
  modport source (output valid, chan_a_out, chan_b_out, chan_c_out, out_row, out_col,
                  frame_end, input ready);
  modport sink   (input valid, chan_a_out, chan_b_out, chan_c_out, out_row, out_col,
                  frame_end, output ready);
endinterface

// File: hdl/gbr_line_buf.sv
// Two-row line store as one memory of {upper, lower} per column, with a
// clearing pass after reset. Depends on gbr_pkg.
module gbr_line_buf import gbr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_addr,
  input  logic [LB_W-1:0]  wr_data,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  output logic [LB_W-1:0]  rd_data,
  output logic             busy
);

  logic [LB_W-1:0]  mem [MAX_WIDTH];
  logic [COL_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == COL_W'(MAX_WIDTH - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // prefetch register; zero matches the cleared memory at column 0
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_data <= '0;
    end else if (rd_en && !busy) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/gbr_lane.sv
// One color-channel lane: tap sums, weight products, round and saturate.
// Depends on gbr_pkg.
module gbr_lane import gbr_pkg::*; (
  input  logic            clk,
  input  gbr_ctrl_t       ctrl,
  input  gbr_weights_t    wts,
  input  logic [8:0][7:0] tap,   // row-major 3x3, tap[4] is the center
  output logic [7:0]      pix
);

  logic [7:0]  c1;
  logic [9:0]  e1, k1;
  logic [20:0] pc;
  logic [22:0] pe, pk;
  logic [24:0] acc;
  logic [12:0] rnd;

  always_ff @(posedge clk) begin
    if (ctrl.en1) begin
      c1 <= tap[4];
      e1 <= 10'(tap[1]) + 10'(tap[3]) + 10'(tap[5]) + 10'(tap[7]);
      k1 <= 10'(tap[0]) + 10'(tap[2]) + 10'(tap[6]) + 10'(tap[8]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en2) begin
      pc <= 21'(c1) * 21'(wts.center);
      pe <= 23'(e1) * 23'(wts.edge_w);
      pk <= 23'(k1) * 23'(wts.corner);
    end
  end

  assign acc = 25'(pc) + 25'(pe) + 25'(pk) + 25'd2048;
  assign rnd = acc[24:12];

  always_ff @(posedge clk) begin
    if (ctrl.en3) begin
      pix <= (rnd > 13'd255) ? 8'hFF : rnd[7:0];
    end
  end

endmodule

// File: hdl/gaussian_blur_3x3_rgb.sv
// Top level of the 3x3 Gaussian blur: APB registers, raster counters, window,
// three channel lanes and the merged output item. Depends on gbr_pkg, gbr_if,
// gbr_line_buf and gbr_lane.
//
// Usage: pixels stream in raster order on pix_in, one transfer per pixel.
// For each pixel at row >= 2 and column >= 2 one filtered item, centered one
// row up and one column left, leaves on pix_out with its row, column and a
// frame_end flag on the last interior pixel. Border pixels give no item.
// Pipeline: three register stages (tap sums, weight products, rounding into the
// output register); the first loads at the input transfer edge, and the output
// register holds its result until pix_out takes it.
// Throughput: one pixel per cycle while pix_out is taken; the line store is read
// one column ahead at each transfer so the single memory port keeps up.
// Reset: a clearing pass writes zero into all MAX_WIDTH (1024) columns of the
// line store, one per cycle; pix_in.ready stays low until the pass ends.
// Registers take APB writes throughout and come back at their reset values.
// Stall: when pix_out is not taken, the pipeline keeps accepting until its
// two internal stages fill behind the held output, then lowers pix_in.ready.
// Registers should be written only while the stream is idle.
module gaussian_blur_3x3_rgb import gbr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  gbr_in_if.sink       pix_in,
  gbr_out_if.source    pix_out,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // ---------------- configuration registers ----------------
  logic [10:0]  image_width, image_height;
  gbr_weights_t wts;
  logic         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd1024;
      image_height <= 11'd1024;
      wts.center   <= 13'd836;
      wts.edge_w   <= 13'd507;
      wts.corner   <= 13'd308;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_WIDTH:  image_width  <= pwdata[10:0];
        REG_HEIGHT: image_height <= pwdata[10:0];
        REG_WC:     wts.center   <= pwdata[12:0];
        REG_WE:     wts.edge_w   <= pwdata[12:0];
        REG_WK:     wts.corner   <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      REG_WC:     prdata = 32'(wts.center);
      REG_WE:     prdata = 32'(wts.edge_w);
      REG_WK:     prdata = 32'(wts.corner);
      default:    prdata = 32'd0;
    endcase
  end

  // ---------------- frame geometry, clamped ----------------
  logic [WX-1:0]    width_x;
  logic [COL_W-1:0] w_m1;
  logic [9:0]       h_m1;

  assign width_x = WX'(image_width);

  always_comb begin
    if (image_width < 11'd3) begin
      w_m1 = COL_W'(2);
    end else if (width_x > WX'(MAX_WIDTH)) begin
      w_m1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_m1 = COL_W'(width_x - 1'b1);
    end
    if (image_height < 11'd3) begin
      h_m1 = 10'd2;
    end else if (image_height > 11'd1024) begin
      h_m1 = 10'd1023;
    end else begin
      h_m1 = 10'(image_height - 11'd1);
    end
  end

  // ---------------- handshake and pipeline enables ----------------
  gbr_ctrl_t ctrl;
  logic      v1, v2, ov;
  logic      lb_busy, fire;

  assign ctrl.en3     = !ov || pix_out.ready;
  assign ctrl.en2     = !v2 || ctrl.en3;
  assign ctrl.en1     = !v1 || ctrl.en2;
  assign pix_in.ready = !lb_busy && ctrl.en1;
  assign fire         = pix_in.valid && pix_in.ready;

  // ---------------- counters, window, line store ----------------
  logic [COL_W-1:0] col_count, col_next;
  logic [9:0]       row_count;
  logic             last_col, last_row, emit;
  logic [23:0]      px, top, mid;
  logic [5:0][23:0] win;
  logic [LB_W-1:0]  lb_rd;

  assign px       = {pix_in.chan_c_in, pix_in.chan_b_in, pix_in.chan_a_in};
  assign top      = lb_rd[47:24];
  assign mid      = lb_rd[23:0];
  assign last_col = col_count >= w_m1;
  assign last_row = row_count >= h_m1;
  assign emit     = (row_count >= 10'd2) && (col_count >= COL_W'(2));
  assign col_next = last_col ? '0 : col_count + 1'b1;

  gbr_line_buf u_line_buf (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fire),
    .wr_addr (col_count),
    .wr_data ({mid, px}),  // upper takes the old lower row, lower the new pixel
    .rd_en   (fire),
    .rd_addr (col_next),   // never equal to col_count, so no write collision
    .rd_data (lb_rd),
    .busy    (lb_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      win       <= '0;
    end else if (fire) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= px;
      col_count <= col_next;
      if (last_col) row_count <= last_row ? 10'd0 : row_count + 10'd1;
    end
  end

  // ---------------- channel lanes ----------------
  logic [NUM_LANES-1:0][7:0] lane_pix;

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    logic [8:0][7:0] tap;
    assign tap = {px[8*k +: 8],     win[5][8*k +: 8], win[2][8*k +: 8],
                  mid[8*k +: 8],    win[4][8*k +: 8], win[1][8*k +: 8],
                  top[8*k +: 8],    win[3][8*k +: 8], win[0][8*k +: 8]};
    gbr_lane u_lane (
      .clk  (clk),
      .ctrl (ctrl),
      .wts  (wts),
      .tap  (tap),
      .pix  (lane_pix[k])
    );
  end

  // ---------------- position side band and merge ----------------
  logic [9:0] row1, col1, row2, col2;
  logic       fe1, fe2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (ctrl.en1) v1 <= fire && emit;
      if (ctrl.en2) v2 <= v1;
      if (ctrl.en3) ov <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en1) begin
      row1 <= row_count - 10'd1;
      col1 <= 10'(col_count - COL_W'(1));
      fe1  <= last_col && last_row;
    end
    if (ctrl.en2) begin
      row2 <= row1;
      col2 <= col1;
      fe2  <= fe1;
    end
    if (ctrl.en3) begin
      pix_out.out_row   <= row2;
      pix_out.out_col   <= col2;
      pix_out.frame_end <= fe2;
    end
  end

  assign pix_out.valid      = ov;
  assign pix_out.chan_a_out = lane_pix[0];
  assign pix_out.chan_b_out = lane_pix[1];
  assign pix_out.chan_c_out = lane_pix[2];

endmodule
